>>> sv/lcfd_pkg.sv
package lcfd_pkg;

    localparam int unsigned HISTORY_DEPTH_DEF = 65536;
    localparam int unsigned SOURCE_LIMIT_DEF  = 65536;
    localparam int unsigned QUEUE_DEPTH       = 2;
    localparam int unsigned POS_W             = 17;
    localparam int unsigned CNT_W             = 16;
    localparam int unsigned APB_AW            = 3;

    localparam logic [POS_W-1:0] LIMIT_RESET = 17'h10000;
    localparam logic [APB_AW-1:0] REG_OUTPUT_LIMIT = 3'd0;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_PULL = 1'b1;

    localparam logic [7:0] CMD_FILL    = 8'hFE;
    localparam logic [7:0] CMD_LONG    = 8'hFF;
    localparam logic [7:0] CMD_ABS_MIN = 8'hC0;
    localparam logic [7:0] CMD_END     = 8'h80;
    localparam logic [CNT_W-1:0] SHORT_BIAS = 16'd3;

    typedef enum logic [3:0] {
        PH_CMD      = 4'd0,
        PH_FILL_LO  = 4'd1,
        PH_FILL_HI  = 4'd2,
        PH_FILL_VAL = 4'd3,
        PH_LONG_LO  = 4'd4,
        PH_LONG_HI  = 4'd5,
        PH_ABS_LO   = 4'd6,
        PH_ABS_HI   = 4'd7,
        PH_LITERAL  = 4'd8,
        PH_REL_LO   = 4'd9,
        PH_FILLING  = 4'd10,
        PH_COPYING  = 4'd11,
        PH_DONE_END = 4'd13,
        PH_DONE_OVF = 4'd14,
        PH_DONE_BAD = 4'd15
    } t_phase;

    typedef enum logic [1:0] {
        ST_DATA = 2'd0,
        ST_END  = 2'd1,
        ST_OVF  = 2'd2,
        ST_BAD  = 2'd3
    } t_status;

    typedef struct packed {
        logic       opcode;
        logic [7:0] data;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_head;

endpackage

>>> sv/lz_copy_fill_decompressor_unit.sv
// LCW style byte-stream decompressor.
// s_axis carries one item per transfer: tuser = opcode (0 push a compressed
// byte in tdata, 1 pull one pending fill or copy byte). m_axis returns at most
// one result per item: tdata = out_byte, status, total_out; tlast = is_last.
// status: 0 data, 1 end of stream, 2 output overflow, 3 bad back reference.
// Literal bytes are answered on their push; fill and copy bytes on pulls.
// A push while fill/copy bytes are pending, or a pull with nothing pending,
// gives no result. After a stop every item answers the stop status.
// Throughput is one item per cycle while no result waits on m_axis_tready; the
// history memory is read and written once per cycle, the byte of the previous item forwarded.
// From input transfer to result an item passes the input queue, then the
// output register that also holds the history read data.
// The input queue keeps accepting while a result waits; when m_axis_tready
// is low the back stage holds and the queue fills, then s_axis_tready drops.
// Reset clears the parser to await a command, all counts to zero and the
// output_limit register (APB offset 0) to 65536; history needs no clearing.
module lz_copy_fill_decompressor_unit #(
    parameter int unsigned HISTORY_DEPTH = lcfd_pkg::HISTORY_DEPTH_DEF,
    parameter int unsigned SOURCE_LIMIT  = lcfd_pkg::SOURCE_LIMIT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [7:0]                  s_axis_tdata,   // in_byte
    input  logic                        s_axis_tuser,   // opcode
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [31:0]                 m_axis_tdata,   // out_byte, status, total_out, zero pad
    output logic                        m_axis_tlast,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lcfd_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import lcfd_pkg::*;

    logic [POS_W-1:0] r_limit;
    t_item            in_item;
    t_head            head;
    logic             pop;
    logic [7:0]       out_byte;
    logic [1:0]       out_status;
    logic [POS_W-1:0] out_total;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_OUTPUT_LIMIT) ? {15'd0, r_limit} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (psel && penable && pwrite && pready && paddr == REG_OUTPUT_LIMIT) begin
            r_limit <= pwdata[POS_W-1:0];
        end
    end

    assign in_item.opcode = s_axis_tuser;
    assign in_item.data   = s_axis_tdata;

    lcfd_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (in_item),
        .o_head  (head),
        .i_pop   (pop)
    );

    lcfd_back #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .SOURCE_LIMIT  (SOURCE_LIMIT)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_limit  (r_limit),
        .i_head   (head),
        .o_pop    (pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_byte   (out_byte),
        .o_status (out_status),
        .o_last   (m_axis_tlast),
        .o_total  (out_total)
    );

    assign m_axis_tdata = {5'd0, out_total, out_status, out_byte};

`ifndef SYNTHESIS
    a_stop_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[9:8] != ST_DATA) |-> m_axis_tlast)
        else $error("stop status without tlast");

    a_data_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[9:8] == ST_DATA) |-> (m_axis_tdata[26:10] != '0))
        else $error("data byte with zero total");

    a_stop_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[9:8] != ST_DATA) |-> (m_axis_tdata[7:0] == 8'd0))
        else $error("stop result carries a byte");
`endif

endmodule

>>> sv/lcfd_front.sv
module lcfd_front #(
    parameter int unsigned DEPTH = lcfd_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  lcfd_pkg::t_item i_item,
    output lcfd_pkg::t_head o_head,
    input  logic           i_pop
);
    import lcfd_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_item          r_q [DEPTH];
    logic [PW-1:0]  r_wr, r_rd;
    logic [CW-1:0]  r_cnt;
    logic           push, pop;

    assign o_ready     = (r_cnt != CW'(DEPTH));
    assign push        = i_valid && o_ready;
    assign pop         = i_pop && (r_cnt != '0);
    assign o_head.valid = (r_cnt != '0);
    assign o_head.item  = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

>>> sv/lcfd_back.sv
module lcfd_back #(
    parameter int unsigned HISTORY_DEPTH = lcfd_pkg::HISTORY_DEPTH_DEF,
    parameter int unsigned SOURCE_LIMIT  = lcfd_pkg::SOURCE_LIMIT_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [lcfd_pkg::POS_W-1:0] i_limit,
    input  lcfd_pkg::t_head            i_head,
    output logic                       o_pop,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [7:0]                 o_byte,
    output logic [1:0]                 o_status,
    output logic                       o_last,
    output logic [lcfd_pkg::POS_W-1:0] o_total
);
    import lcfd_pkg::*;

    localparam int unsigned AW = $clog2(HISTORY_DEPTH);

    t_phase            r_phase, n_phase;
    logic [7:0]        r_cmd, n_cmd, r_fill, n_fill;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [POS_W-1:0]  r_cp, n_cp, r_wp, n_wp, r_bc;

    // history and its registered read port
    logic [7:0]        r_mem [HISTORY_DEPTH];
    logic [7:0]        r_rdata;

    // output stage
    logic              r_b_valid, r_b_has, r_b_last, r_b_mem, r_b_fwd, r_b_we;
    t_status           r_b_status;
    logic [POS_W-1:0]  r_b_total;
    logic [7:0]        r_b_byte, r_b_fbyte;
    logic [AW-1:0]     r_b_waddr;
    logic [7:0]        b_byte;

    logic              advance, go, op, fin, running, push_take, src_hit;
    logic [7:0]        b;
    logic [POS_W-1:0]  bc_after, lim;
    logic [CNT_W-1:0]  cmd_len, len, cnt_dec;
    logic              ovf, bad_rel, cnt_done, copy_bad;
    logic [11:0]       rel_dist;
    t_phase            to_cmd_ph;
    logic [AW-1:0]     raddr, waddr;

    logic              a_has, a_last, a_we, a_rd, a_mem;
    t_status           a_status;
    logic [7:0]        a_byte;

    assign advance = !(r_b_valid && r_b_has && !i_ready);
    assign go      = i_head.valid && advance;
    assign o_pop   = go;
    assign op      = i_head.item.opcode;
    assign b       = i_head.item.data;

    assign fin     = (r_phase == PH_DONE_END) || (r_phase == PH_DONE_OVF)
                  || (r_phase == PH_DONE_BAD);
    assign running = (r_phase == PH_FILLING) || (r_phase == PH_COPYING);
    assign push_take = go && !fin && (op == OP_PUSH) && !running;
    assign bc_after  = (push_take && (r_bc != '1)) ? r_bc + 1'b1 : r_bc;
    assign src_hit   = 32'(bc_after) >= 32'(SOURCE_LIMIT);
    assign to_cmd_ph = src_hit ? PH_DONE_END : PH_CMD;

    assign lim     = (32'(i_limit) > 32'(HISTORY_DEPTH)) ? POS_W'(HISTORY_DEPTH) : i_limit;
    assign cmd_len = {10'd0, b[5:0]};
    assign len     = (r_phase == PH_CMD) ? cmd_len : r_count;
    assign ovf     = ({1'b0, r_wp} + {2'b0, len}) > {1'b0, lim};
    assign rel_dist = {r_cmd[3:0], b};
    assign bad_rel = {5'd0, rel_dist} > r_wp;
    assign cnt_dec = (r_count != '0) ? r_count - 1'b1 : r_count;
    assign cnt_done = (cnt_dec == '0);
    assign copy_bad = (r_cp >= r_wp) || (32'(r_cp) >= 32'(HISTORY_DEPTH));
    assign raddr   = AW'(r_cp);
    assign waddr   = AW'(r_wp);

    // next state of the command parser
    always_comb begin
        n_phase = r_phase;
        if (go && !fin) begin
            if (op == OP_PUSH) begin
                unique case (r_phase)
                    PH_CMD: begin
                        priority if (b == CMD_END) begin
                            n_phase = PH_DONE_END;
                        end else if (b == CMD_FILL) begin
                            n_phase = PH_FILL_LO;
                        end else if (b == CMD_LONG) begin
                            n_phase = PH_LONG_LO;
                        end else if (b >= CMD_ABS_MIN) begin
                            n_phase = PH_ABS_LO;
                        end else if (b > CMD_END) begin
                            n_phase = ovf ? PH_DONE_OVF : PH_LITERAL;
                        end else begin
                            n_phase = PH_REL_LO;
                        end
                    end
                    PH_FILL_LO:  n_phase = PH_FILL_HI;
                    PH_FILL_HI:  n_phase = PH_FILL_VAL;
                    PH_FILL_VAL: n_phase = ovf ? PH_DONE_OVF :
                                           (r_count == '0) ? to_cmd_ph : PH_FILLING;
                    PH_LONG_LO:  n_phase = PH_LONG_HI;
                    PH_LONG_HI:  n_phase = PH_ABS_LO;
                    PH_ABS_LO:   n_phase = PH_ABS_HI;
                    PH_ABS_HI:   n_phase = ovf ? PH_DONE_OVF :
                                           (r_count == '0) ? to_cmd_ph : PH_COPYING;
                    PH_REL_LO:   n_phase = ovf ? PH_DONE_OVF :
                                           bad_rel ? PH_DONE_BAD : PH_COPYING;
                    PH_LITERAL:  n_phase = cnt_done ? to_cmd_ph : PH_LITERAL;
                    default:     n_phase = r_phase;
                endcase
            end else begin
                unique case (r_phase)
                    PH_FILLING: n_phase = cnt_done ? to_cmd_ph : PH_FILLING;
                    PH_COPYING: n_phase = copy_bad ? PH_DONE_BAD :
                                          cnt_done ? to_cmd_ph : PH_COPYING;
                    default:    n_phase = r_phase;
                endcase
            end
        end
    end

    // datapath updates and result of the item taken this cycle
    always_comb begin
        n_cmd    = r_cmd;
        n_fill   = r_fill;
        n_count  = r_count;
        n_cp     = r_cp;
        n_wp     = r_wp;
        a_has    = 1'b0;
        a_last   = 1'b0;
        a_status = ST_DATA;
        a_we     = 1'b0;
        a_rd     = 1'b0;
        a_mem    = 1'b0;
        a_byte   = 8'd0;
        if (go) begin
            if (fin) begin
                a_has    = 1'b1;
                a_last   = 1'b1;
                a_status = t_status'(r_phase[1:0]);
            end else if (op == OP_PUSH) begin
                unique case (r_phase)
                    PH_CMD: begin
                        n_cmd = b;
                        priority if (b == CMD_END) begin
                            a_has    = 1'b1;
                            a_last   = 1'b1;
                            a_status = ST_END;
                        end else if (b == CMD_FILL || b == CMD_LONG) begin
                            n_count = r_count;
                        end else if (b >= CMD_ABS_MIN) begin
                            n_count = cmd_len + SHORT_BIAS;
                        end else if (b > CMD_END) begin
                            n_count = cmd_len;
                            if (ovf) begin
                                a_has    = 1'b1;
                                a_last   = 1'b1;
                                a_status = ST_OVF;
                            end
                        end else begin
                            n_count = {12'd0, b[7:4]} + SHORT_BIAS;
                        end
                    end
                    PH_FILL_LO, PH_LONG_LO: n_count = {8'd0, b};
                    PH_FILL_HI, PH_LONG_HI: n_count = {b, r_count[7:0]};
                    PH_ABS_LO: n_cp = {9'd0, b};
                    PH_FILL_VAL, PH_ABS_HI: begin
                        if (r_phase == PH_FILL_VAL) begin
                            n_fill = b;
                        end else begin
                            n_cp = {1'b0, b, r_cp[7:0]};
                        end
                        if (ovf) begin
                            a_has    = 1'b1;
                            a_last   = 1'b1;
                            a_status = ST_OVF;
                        end else if (r_count == '0 && src_hit) begin
                            a_has    = 1'b1;
                            a_last   = 1'b1;
                            a_status = ST_END;
                        end
                    end
                    PH_REL_LO: begin
                        if (ovf) begin
                            a_has    = 1'b1;
                            a_last   = 1'b1;
                            a_status = ST_OVF;
                        end else if (bad_rel) begin
                            a_has    = 1'b1;
                            a_last   = 1'b1;
                            a_status = ST_BAD;
                        end else begin
                            n_cp = r_wp - {5'd0, rel_dist};
                        end
                    end
                    PH_LITERAL: begin
                        a_we    = 1'b1;
                        a_byte  = b;
                        n_wp    = r_wp + 1'b1;
                        n_count = cnt_dec;
                        a_has   = 1'b1;
                        a_last  = cnt_done && src_hit;
                    end
                    default: n_count = r_count;
                endcase
            end else begin
                unique case (r_phase)
                    PH_FILLING: begin
                        a_we    = 1'b1;
                        a_byte  = r_fill;
                        n_wp    = r_wp + 1'b1;
                        n_count = cnt_dec;
                        a_has   = 1'b1;
                        a_last  = cnt_done && src_hit;
                    end
                    PH_COPYING: begin
                        a_has = 1'b1;
                        if (copy_bad) begin
                            a_last   = 1'b1;
                            a_status = ST_BAD;
                        end else begin
                            a_rd    = 1'b1;
                            a_mem   = 1'b1;
                            a_we    = 1'b1;
                            n_cp    = r_cp + 1'b1;
                            n_wp    = r_wp + 1'b1;
                            n_count = cnt_dec;
                            a_last  = cnt_done && src_hit;
                        end
                    end
                    default: n_wp = r_wp;
                endcase
            end
        end
    end

    // copy byte comes from the read port, or from the byte written just before it
    assign b_byte = r_b_mem ? (r_b_fwd ? r_b_fbyte : r_rdata) : r_b_byte;

    always_ff @(posedge i_clk) begin
        if (r_b_valid && r_b_we && advance) begin
            r_mem[r_b_waddr] <= b_byte;
        end
        if (a_rd) begin
            r_rdata <= r_mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_b_has    <= a_has;
            r_b_last   <= a_last;
            r_b_status <= a_status;
            r_b_total  <= n_wp;
            r_b_byte   <= a_byte;
            r_b_mem    <= a_mem;
            r_b_we     <= a_we && (32'(r_wp) < 32'(HISTORY_DEPTH));
            r_b_waddr  <= waddr;
            r_b_fwd    <= r_b_valid && r_b_we && (r_b_waddr == raddr);
            r_b_fbyte  <= b_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_CMD;
            r_cmd     <= '0;
            r_fill    <= '0;
            r_count   <= '0;
            r_cp      <= '0;
            r_wp      <= '0;
            r_bc      <= '0;
            r_b_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_b_valid <= go;
            end
            if (go) begin
                r_phase <= n_phase;
                r_cmd   <= n_cmd;
                r_fill  <= n_fill;
                r_count <= n_count;
                r_cp    <= n_cp;
                r_wp    <= n_wp;
                r_bc    <= bc_after;
            end
        end
    end

    assign o_valid  = r_b_valid && r_b_has;
    assign o_byte   = b_byte;
    assign o_status = r_b_status;
    assign o_last   = r_b_last;
    assign o_total  = r_b_total;

endmodule
